// File: rtl/pscc_pkg.sv
package pscc_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRAC_BITS_DEF = 10;
    localparam int CFG_W         = 16;
    localparam int CFG_AW        = 1;

    localparam logic [CFG_W-1:0] SHORT_TERM_RST = 16'd1229;
    localparam logic [CFG_W-1:0] MARGIN_RST     = 16'd512;

    localparam logic [CFG_AW-1:0] REG_SHORT_TERM = 1'd0;
    localparam logic [CFG_AW-1:0] REG_MARGIN     = 1'd1;

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int SQW  = 2 * COORD_BITS;
    localparam int D2W  = SQW + 2;
    localparam int LW   = COORD_BITS + 1;
    localparam int EW   = COORD_BITS + 2;
    localparam int EMW  = COORD_BITS + 1;
    localparam int ESQW = 2 * EMW;
    localparam int BW   = ((LW > CFG_W) ? LW : CFG_W) + 1;
    localparam int BSQW = 2 * BW;

    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_POS     = 3'd1,
        CAUSE_GOAL    = 3'd2,
        CAUSE_CROSS   = 3'd3,
        CAUSE_OVERLAP = 3'd4
    } cause_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t own_pos_x;
        coord_t own_pos_y;
        coord_t own_goal_x;
        coord_t own_goal_y;
        coord_t other_start_x;
        coord_t other_start_y;
        coord_t other_start_z;
        coord_t other_end_x;
        coord_t other_end_y;
        coord_t other_end_z;
    } item_t;

    typedef struct packed {
        logic [ESQW-1:0] esq_px;
        logic [ESQW-1:0] esq_py;
        logic [ESQW-1:0] esq_gx;
        logic [ESQW-1:0] esq_gy;
        cause_t          seg_cause;
    } ell_t;

    typedef struct packed {
        logic [D2W-1:0] d2;
        ell_t           ell;
    } front_t;

    typedef struct packed {
        logic [LW-1:0] len;
        ell_t          ell;
    } root_t;

endpackage

// File: rtl/path_segment_conflict_check.sv
// Pairwise conflict check of an own motion segment against another vehicle's path segment.
// Input channel in_valid/in_ready: one transfer carries own position and waypoint (x, y) and
// the other segment's start and end (x, y, z), signed Q5.10.
// Output channel out_valid/out_ready: one transfer per input, in order, with conflict and cause
// (0 none, 1 position in guard ellipse, 2 waypoint in guard ellipse, 3 crossing,
// 4 collinear overlap).
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 short-axis weight,
// 1 long-axis margin); write only while no transfer is in flight.
// Pipeline: 2 front stages, 17 square-root stages at one root bit each, 4 guard stages.
// Throughput: one transfer per cycle while the output is not stalled.
// Reset clears all stage valid bits and loads the register defaults (1.2 and 0.5).
// When out_ready is low the result holds; empty stages keep filling, and in_ready
// drops only once every stage holds an item.
module path_segment_conflict_check #(
    parameter int FRAC_BITS = pscc_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pscc_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [pscc_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [pscc_pkg::COORD_BITS-1:0] own_pos_x,
    input  logic signed [pscc_pkg::COORD_BITS-1:0] own_pos_y,
    input  logic signed [pscc_pkg::COORD_BITS-1:0] own_goal_x,
    input  logic signed [pscc_pkg::COORD_BITS-1:0] own_goal_y,
    input  logic signed [pscc_pkg::COORD_BITS-1:0] other_start_x,
    input  logic signed [pscc_pkg::COORD_BITS-1:0] other_start_y,
    input  logic signed [pscc_pkg::COORD_BITS-1:0] other_start_z,
    input  logic signed [pscc_pkg::COORD_BITS-1:0] other_end_x,
    input  logic signed [pscc_pkg::COORD_BITS-1:0] other_end_y,
    input  logic signed [pscc_pkg::COORD_BITS-1:0] other_end_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                conflict,
    output logic [2:0]                          cause
);
    import pscc_pkg::*;

    logic [CFG_W-1:0] short_term_reg;
    logic [CFG_W-1:0] margin_reg;
    logic [CFG_W-1:0] short_term_next;
    logic [CFG_W-1:0] margin_next;

    item_t  item;
    front_t front_data;
    root_t  root_data;
    logic   front_valid;
    logic   front_ready;
    logic   root_valid;
    logic   root_ready;

    always_comb
    begin
        short_term_next = short_term_reg;
        margin_next     = margin_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SHORT_TERM: short_term_next = cfg_wdata;
                REG_MARGIN:     margin_next     = cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_term_reg <= SHORT_TERM_RST;
            margin_reg     <= MARGIN_RST;
        end
        else
        begin
            short_term_reg <= short_term_next;
            margin_reg     <= margin_next;
        end
    end

    assign item = '{
        own_pos_x:     own_pos_x,
        own_pos_y:     own_pos_y,
        own_goal_x:    own_goal_x,
        own_goal_y:    own_goal_y,
        other_start_x: other_start_x,
        other_start_y: other_start_y,
        other_start_z: other_start_z,
        other_end_x:   other_end_x,
        other_end_y:   other_end_y,
        other_end_z:   other_end_z
    };

    pscc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (item),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    pscc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_data  (root_data)
    );

    pscc_guard #(
        .FRAC_BITS (FRAC_BITS)
    ) u_guard (
        .clk        (clk),
        .rst_n      (rst_n),
        .short_term (short_term_reg),
        .margin     (margin_reg),
        .in_valid   (root_valid),
        .in_ready   (root_ready),
        .in_data    (root_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .conflict   (conflict),
        .cause      (cause)
    );

endmodule

// File: rtl/pscc_front.sv
module pscc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pscc_pkg::item_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output pscc_pkg::front_t out_data
);
    import pscc_pkg::*;

    localparam logic [1:0] ORI_COL = 2'd0;
    localparam logic [1:0] ORI_POS = 2'd1;
    localparam logic [1:0] ORI_NEG = 2'd2;

    typedef struct packed {
        logic signed [PW-1:0] a;
        logic signed [PW-1:0] b;
    } cross_t;

    function automatic logic signed [DW-1:0] sdiff(input coord_t x, input coord_t y);
        sdiff = DW'(x) - DW'(y);
    endfunction

    function automatic logic signed [PW-1:0] tprod(input logic signed [DW-1:0] x,
                                                  input logic signed [DW-1:0] y);
        tprod = PW'(x) * PW'(y);
    endfunction

    function automatic cross_t cross_terms(input coord_t px, input coord_t py,
                                           input coord_t qx, input coord_t qy,
                                           input coord_t rx, input coord_t ry);
        cross_t c;
        c.a = tprod(sdiff(qy, py), sdiff(rx, qx));
        c.b = tprod(sdiff(qx, px), sdiff(ry, qy));
        cross_terms = c;
    endfunction

    function automatic logic onseg(input coord_t px, input coord_t py,
                                   input coord_t qx, input coord_t qy,
                                   input coord_t rx, input coord_t ry);
        onseg = ((qx >= px && qx <= rx) || (qx >= rx && qx <= px)) &&
                ((qy >= py && qy <= ry) || (qy >= ry && qy <= py));
    endfunction

    function automatic logic [EMW-1:0] emag(input coord_t q, input coord_t s,
                                            input coord_t e);
        logic signed [EW-1:0] t;
        t = (EW'(q) <<< 1) - EW'(s) - EW'(e);
        emag = t[EW-1] ? EMW'(-t) : EMW'(t);
    endfunction

    function automatic logic [1:0] orient(input cross_t c);
        logic signed [PW:0] d;
        d = (PW+1)'(c.a) - (PW+1)'(c.b);
        if (d == '0)
            orient = ORI_COL;
        else if (d[PW])
            orient = ORI_NEG;
        else
            orient = ORI_POS;
    endfunction

    logic           v1_reg;
    logic           v2_reg;
    logic           rdy1;
    logic           rdy2;
    logic [SQW-1:0] sqx_reg;
    logic [SQW-1:0] sqy_reg;
    logic [SQW-1:0] sqz_reg;
    cross_t         cross_reg [4];
    logic [EMW-1:0] emag_reg  [4];
    logic [3:0]     onseg_reg;
    front_t         data2_reg;

    logic [SQW-1:0] sqx_next;
    logic [SQW-1:0] sqy_next;
    logic [SQW-1:0] sqz_next;
    cross_t         cross_next [4];
    logic [EMW-1:0] emag_next  [4];
    logic [3:0]     onseg_next;
    front_t         data2_next;

    logic signed [PW-1:0] sq_x;
    logic signed [PW-1:0] sq_y;
    logic signed [PW-1:0] sq_z;
    logic [1:0]           ori [4];

    assign rdy2      = !v2_reg || out_ready;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v2_reg;
    assign out_data  = data2_reg;

    always_comb
    begin
        sq_x = tprod(sdiff(in_item.other_end_x, in_item.other_start_x),
                     sdiff(in_item.other_end_x, in_item.other_start_x));
        sq_y = tprod(sdiff(in_item.other_end_y, in_item.other_start_y),
                     sdiff(in_item.other_end_y, in_item.other_start_y));
        sq_z = tprod(sdiff(in_item.other_end_z, in_item.other_start_z),
                     sdiff(in_item.other_end_z, in_item.other_start_z));
        sqx_next = sq_x[SQW-1:0];
        sqy_next = sq_y[SQW-1:0];
        sqz_next = sq_z[SQW-1:0];

        cross_next[0] = cross_terms(in_item.own_pos_x, in_item.own_pos_y,
                                    in_item.own_goal_x, in_item.own_goal_y,
                                    in_item.other_start_x, in_item.other_start_y);
        cross_next[1] = cross_terms(in_item.own_pos_x, in_item.own_pos_y,
                                    in_item.own_goal_x, in_item.own_goal_y,
                                    in_item.other_end_x, in_item.other_end_y);
        cross_next[2] = cross_terms(in_item.other_start_x, in_item.other_start_y,
                                    in_item.other_end_x, in_item.other_end_y,
                                    in_item.own_pos_x, in_item.own_pos_y);
        cross_next[3] = cross_terms(in_item.other_start_x, in_item.other_start_y,
                                    in_item.other_end_x, in_item.other_end_y,
                                    in_item.own_goal_x, in_item.own_goal_y);

        onseg_next[0] = onseg(in_item.own_pos_x, in_item.own_pos_y,
                              in_item.other_start_x, in_item.other_start_y,
                              in_item.own_goal_x, in_item.own_goal_y);
        onseg_next[1] = onseg(in_item.own_pos_x, in_item.own_pos_y,
                              in_item.other_end_x, in_item.other_end_y,
                              in_item.own_goal_x, in_item.own_goal_y);
        onseg_next[2] = onseg(in_item.other_start_x, in_item.other_start_y,
                              in_item.own_pos_x, in_item.own_pos_y,
                              in_item.other_end_x, in_item.other_end_y);
        onseg_next[3] = onseg(in_item.other_start_x, in_item.other_start_y,
                              in_item.own_goal_x, in_item.own_goal_y,
                              in_item.other_end_x, in_item.other_end_y);

        emag_next[0] = emag(in_item.own_pos_x, in_item.other_start_x, in_item.other_end_x);
        emag_next[1] = emag(in_item.own_pos_y, in_item.other_start_y, in_item.other_end_y);
        emag_next[2] = emag(in_item.own_goal_x, in_item.other_start_x, in_item.other_end_x);
        emag_next[3] = emag(in_item.own_goal_y, in_item.other_start_y, in_item.other_end_y);
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ori[i] = orient(cross_reg[i]);
        end
        data2_next.d2 = D2W'(sqx_reg) + D2W'(sqy_reg) + D2W'(sqz_reg);
        data2_next.ell.esq_px = ESQW'(emag_reg[0]) * ESQW'(emag_reg[0]);
        data2_next.ell.esq_py = ESQW'(emag_reg[1]) * ESQW'(emag_reg[1]);
        data2_next.ell.esq_gx = ESQW'(emag_reg[2]) * ESQW'(emag_reg[2]);
        data2_next.ell.esq_gy = ESQW'(emag_reg[3]) * ESQW'(emag_reg[3]);
        if (ori[0] != ori[1] && ori[2] != ori[3])
            data2_next.ell.seg_cause = CAUSE_CROSS;
        else if ((ori[0] == ORI_COL && onseg_reg[0]) ||
                 (ori[1] == ORI_COL && onseg_reg[1]) ||
                 (ori[2] == ORI_COL && onseg_reg[2]) ||
                 (ori[3] == ORI_COL && onseg_reg[3]))
            data2_next.ell.seg_cause = CAUSE_OVERLAP;
        else
            data2_next.ell.seg_cause = CAUSE_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            sqz_reg   <= sqz_next;
            cross_reg <= cross_next;
            emag_reg  <= emag_next;
            onseg_reg <= onseg_next;
        end
        if (rdy2)
            data2_reg <= data2_next;
    end

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg))
        else $error("front stalls with a free stage");

endmodule

// File: rtl/pscc_sqrt.sv
module pscc_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pscc_pkg::front_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pscc_pkg::root_t  out_data
);
    import pscc_pkg::*;

    logic           v_reg    [LW];
    logic [D2W-1:0] rem_reg  [LW];
    logic [LW-1:0]  root_reg [LW];
    ell_t           ell_reg  [LW];
    logic           rdy      [LW+1];

    assign rdy[LW]   = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[LW-1];
    assign out_data  = '{len: root_reg[LW-1], ell: ell_reg[LW-1]};

    for (genvar j = 0; j < LW; j++)
    begin : g_stage
        localparam int K = LW - 1 - j;

        logic           v_in;
        logic [D2W-1:0] rem_in;
        logic [LW-1:0]  root_in;
        ell_t           ell_in;
        logic [D2W:0]   trial;
        logic           take;
        logic [D2W-1:0] rem_next;
        logic [LW-1:0]  root_next;

        if (j == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = in_data.d2;
            assign root_in = '0;
            assign ell_in  = in_data.ell;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign ell_in  = ell_reg[j-1];
        end

        assign rdy[j]    = !v_reg[j] || rdy[j+1];
        assign trial     = ((D2W+1)'(root_in) << (K + 1)) + ((D2W+1)'(1) << (2 * K));
        assign take      = {1'b0, rem_in} >= trial;
        assign rem_next  = take ? D2W'({1'b0, rem_in} - trial) : rem_in;
        assign root_next = take ? (root_in | (LW'(1) << K)) : root_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (rdy[j])
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j])
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                ell_reg[j]  <= ell_in;
            end
        end
    end

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[LW-1] |-> (rem_reg[LW-1] <= (D2W'(root_reg[LW-1]) << 1)))
        else $error("square root remainder out of range");

endmodule

// File: rtl/pscc_guard.sv
module pscc_guard #(
    parameter int FRAC_BITS = pscc_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pscc_pkg::CFG_W-1:0] short_term,
    input  logic [pscc_pkg::CFG_W-1:0] margin,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  pscc_pkg::root_t            in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       conflict,
    output logic [2:0]                 cause
);
    import pscc_pkg::*;

    localparam int H  = BSQW / 2;
    localparam int HH = BSQW - H;
    localparam int TW = BSQW + ESQW + CFG_W + FRAC_BITS + 2;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    logic [BSQW-1:0]       bsq_reg;
    ell_t                  ell1_reg;
    logic [H+ESQW-1:0]     p_lo_reg;
    logic [HH+ESQW-1:0]    p_hi_reg;
    logic [H+ESQW-1:0]     g_lo_reg;
    logic [HH+ESQW-1:0]    g_hi_reg;
    logic [CFG_W+ESQW-1:0] tp_reg;
    logic [CFG_W+ESQW-1:0] tg_reg;
    logic [CFG_W+BSQW-1:0] rhs_reg;
    cause_t                seg2_reg;
    logic [TW-1:0]         lhs_p_reg;
    logic [TW-1:0]         lhs_g_reg;
    logic [TW-1:0]         rhs3_reg;
    cause_t                seg3_reg;
    cause_t                cause_reg;

    logic [BW-1:0]   b_sum;
    logic [BSQW-1:0] bsq_next;
    logic [TW-1:0]   lhs_p_next;
    logic [TW-1:0]   lhs_g_next;
    logic [TW-1:0]   rhs3_next;
    cause_t          cause_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign out_valid = v4_reg;
    assign cause     = cause_reg;
    assign conflict  = cause_reg != CAUSE_NONE;

    always_comb
    begin
        b_sum    = BW'(in_data.len) + BW'(margin);
        bsq_next = BSQW'(b_sum) * BSQW'(b_sum);

        lhs_p_next = (TW'(p_hi_reg) << H) + TW'(p_lo_reg) + (TW'(tp_reg) << FRAC_BITS);
        lhs_g_next = (TW'(g_hi_reg) << H) + TW'(g_lo_reg) + (TW'(tg_reg) << FRAC_BITS);
        rhs3_next  = TW'(rhs_reg) << (FRAC_BITS + 2);

        if (lhs_p_reg < rhs3_reg)
            cause_next = CAUSE_POS;
        else if (lhs_g_reg < rhs3_reg)
            cause_next = CAUSE_GOAL;
        else
            cause_next = seg3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            bsq_reg  <= bsq_next;
            ell1_reg <= in_data.ell;
        end
        if (rdy2)
        begin
            p_lo_reg <= (H+ESQW)'(bsq_reg[H-1:0]) * (H+ESQW)'(ell1_reg.esq_px);
            p_hi_reg <= (HH+ESQW)'(bsq_reg[BSQW-1:H]) * (HH+ESQW)'(ell1_reg.esq_px);
            g_lo_reg <= (H+ESQW)'(bsq_reg[H-1:0]) * (H+ESQW)'(ell1_reg.esq_gx);
            g_hi_reg <= (HH+ESQW)'(bsq_reg[BSQW-1:H]) * (HH+ESQW)'(ell1_reg.esq_gx);
            tp_reg   <= (CFG_W+ESQW)'(short_term) * (CFG_W+ESQW)'(ell1_reg.esq_py);
            tg_reg   <= (CFG_W+ESQW)'(short_term) * (CFG_W+ESQW)'(ell1_reg.esq_gy);
            rhs_reg  <= (CFG_W+BSQW)'(short_term) * (CFG_W+BSQW)'(bsq_reg);
            seg2_reg <= ell1_reg.seg_cause;
        end
        if (rdy3)
        begin
            lhs_p_reg <= lhs_p_next;
            lhs_g_reg <= lhs_g_next;
            rhs3_reg  <= rhs3_next;
            seg3_reg  <= seg2_reg;
        end
        if (rdy4)
            cause_reg <= cause_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !out_ready) |=> (v4_reg && $stable(cause_reg)))
        else $error("stalled result lost or changed");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import pscc_pkg::*;

    typedef struct {
        item_t pkt;
        int    want;
    } row_t;

    typedef struct {
        logic   conflict;
        cause_t cause;
    } verdict_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;
    logic            in_valid;
    logic            in_ready;
    coord_t          own_pos_x, own_pos_y, own_goal_x, own_goal_y;
    coord_t          other_start_x, other_start_y, other_start_z;
    coord_t          other_end_x, other_end_y, other_end_z;
    logic            out_valid;
    logic            out_ready;
    logic            conflict;
    logic [2:0]      cause;

    logic [CFG_W-1:0] short_term;
    logic [CFG_W-1:0] margin;
    verdict_t         verdict_q[$];
    int               cur_want;
    int               errors;
    bit               quiet;
    bit               hold_req;

    path_segment_conflict_check u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .own_pos_x     (own_pos_x),
        .own_pos_y     (own_pos_y),
        .own_goal_x    (own_goal_x),
        .own_goal_y    (own_goal_y),
        .other_start_x (other_start_x),
        .other_start_y (other_start_y),
        .other_start_z (other_start_z),
        .other_end_x   (other_end_x),
        .other_end_y   (other_end_y),
        .other_end_z   (other_end_z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .conflict      (conflict),
        .cause         (cause)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [127:0] mag128(longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic bit in_guard(longint qx, longint qy, longint cx2, longint cy2,
                                    logic [127:0] bsq, logic [CFG_W-1:0] a);
        logic [127:0] ux, uy, aw, t1, t2, lim;
        ux  = mag128(2 * qx - cx2);
        uy  = mag128(2 * qy - cy2);
        aw  = 128'(a);
        t1  = bsq * ux * ux;
        t2  = (aw * uy * uy) << FRAC_BITS_DEF;
        lim = (aw * bsq) << (FRAC_BITS_DEF + 2);
        return (t1 + t2) < lim;
    endfunction

    function automatic int turn_of(longint px, longint py, longint qx, longint qy,
                                   longint rx, longint ry);
        longint cr;
        cr = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
        return (cr > 0) ? 1 : ((cr < 0) ? 2 : 0);
    endfunction

    function automatic bit within_box(longint px, longint py, longint qx, longint qy,
                                      longint rx, longint ry);
        return qx >= ((px < rx) ? px : rx) && qx <= ((px < rx) ? rx : px) &&
               qy >= ((py < ry) ? py : ry) && qy <= ((py < ry) ? ry : py);
    endfunction

    function automatic cause_t conflict_cause(item_t it, logic [CFG_W-1:0] a,
                                              logic [CFG_W-1:0] m);
        longint px, py, gx, gy, sx, sy, sz, ex, ey, ez, cx2, cy2;
        logic [127:0] d2, root, c, b, bsq;
        int o1, o2, o3, o4;
        px = longint'(it.own_pos_x);      py = longint'(it.own_pos_y);
        gx = longint'(it.own_goal_x);     gy = longint'(it.own_goal_y);
        sx = longint'(it.other_start_x);  sy = longint'(it.other_start_y);
        sz = longint'(it.other_start_z);
        ex = longint'(it.other_end_x);    ey = longint'(it.other_end_y);
        ez = longint'(it.other_end_z);
        d2 = mag128(ex - sx) * mag128(ex - sx) + mag128(ey - sy) * mag128(ey - sy) +
             mag128(ez - sz) * mag128(ez - sz);
        root = '0;
        for (int bitn = 40; bitn >= 0; bitn--)
        begin
            c = root | (128'd1 << bitn);
            if (c * c <= d2)
                root = c;
        end
        b   = root + 128'(m);
        bsq = b * b;
        cx2 = sx + ex;
        cy2 = sy + ey;
        if (in_guard(px, py, cx2, cy2, bsq, a))
            return CAUSE_POS;
        if (in_guard(gx, gy, cx2, cy2, bsq, a))
            return CAUSE_GOAL;
        o1 = turn_of(px, py, gx, gy, sx, sy);
        o2 = turn_of(px, py, gx, gy, ex, ey);
        o3 = turn_of(sx, sy, ex, ey, px, py);
        o4 = turn_of(sx, sy, ex, ey, gx, gy);
        if (o1 != o2 && o3 != o4)
            return CAUSE_CROSS;
        if ((o1 == 0 && within_box(px, py, sx, sy, gx, gy)) ||
            (o2 == 0 && within_box(px, py, ex, ey, gx, gy)) ||
            (o3 == 0 && within_box(sx, sy, px, py, ex, ey)) ||
            (o4 == 0 && within_box(sx, sy, gx, gy, ex, ey)))
            return CAUSE_OVERLAP;
        return CAUSE_NONE;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge clk)
    begin
        verdict_t v;
        item_t    it;
        if (rst_n && in_valid && in_ready)
        begin
            it = '{own_pos_x, own_pos_y, own_goal_x, own_goal_y, other_start_x,
                   other_start_y, other_start_z, other_end_x, other_end_y, other_end_z};
            v.cause    = (cur_want >= 0) ? cause_t'(cur_want)
                                         : conflict_cause(it, short_term, margin);
            v.conflict = (v.cause != CAUSE_NONE);
            verdict_q.insert(verdict_q.size(), v);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
                report("unexpected transfer", int'(cause), -1);
            else
            begin
                v = verdict_q.pop_front();
                if (conflict !== v.conflict)
                    report("conflict", int'(conflict), int'(v.conflict));
                if (cause !== v.cause)
                    report("cause", int'(cause), int'(v.cause));
            end
        end
    end

    function automatic coord_t near(int span);
        return coord_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic item_t make_item();
        item_t it;
        int    sel, bx, by, dx, dy;
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            it = item_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        end
        else if (sel < 50)
        begin
            dx = (sel < 30) ? 3000 : 8000;
            it = '{near(dx), near(dx), near(dx), near(dx), near(dx), near(dx),
                   near(2000), near(dx), near(dx), near(2000)};
            if (sel >= 42)
            begin
                it.own_goal_x = it.other_start_x;
                it.own_goal_y = it.other_start_y;
            end
        end
        else
        begin
            bx = int'(near(4000));
            by = int'(near(4000));
            dx = int'(near(40));
            dy = int'(near(40));
            it.own_pos_x     = coord_t'(bx + near(200) * dx);
            it.own_pos_y     = coord_t'(by + near(200) * dy);
            it.own_goal_x    = coord_t'(bx + near(200) * dx);
            it.own_goal_y    = coord_t'(by + near(200) * dy);
            it.other_start_x = coord_t'(bx + near(200) * dx);
            it.other_start_y = coord_t'(by + near(200) * dy);
            it.other_end_x   = coord_t'(bx + near(200) * dx);
            it.other_end_y   = coord_t'(by + near(200) * dy);
            it.other_start_z = near(2000);
            it.other_end_z   = near(2000);
            if (sel >= 85)
            begin
                if (sel[0])
                begin
                    it.own_goal_x = it.own_pos_x;
                    it.own_goal_y = it.own_pos_y;
                end
                else
                begin
                    it.other_end_x = it.other_start_x;
                    it.other_end_y = it.other_start_y;
                end
            end
            else if (sel < 58)
            begin
                it.own_pos_y  = coord_t'(it.own_pos_y + near(3));
                it.own_goal_x = coord_t'(it.own_goal_x + near(3));
            end
        end
        return it;
    endfunction

    task automatic send(item_t it, int want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        own_pos_x     <= it.own_pos_x;
        own_pos_y     <= it.own_pos_y;
        own_goal_x    <= it.own_goal_x;
        own_goal_y    <= it.own_goal_y;
        other_start_x <= it.other_start_x;
        other_start_y <= it.other_start_y;
        other_start_z <= it.other_start_z;
        other_end_x   <= it.other_end_x;
        other_end_y   <= it.other_end_y;
        other_end_z   <= it.other_end_z;
        cur_want      <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SHORT_TERM)
            short_term = val;
        else
            margin = val;
        @(negedge clk);
    endtask

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (150) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = quiet ? 0 : $urandom_range(0, 8);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        row_t             rows[$];
        logic [CFG_W-1:0] cfg_set[8][2];
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        own_pos_x     = '0;
        own_pos_y     = '0;
        own_goal_x    = '0;
        own_goal_y    = '0;
        other_start_x = '0;
        other_start_y = '0;
        other_start_z = '0;
        other_end_x   = '0;
        other_end_y   = '0;
        other_end_z   = '0;
        cur_want      = -1;
        errors        = 0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        short_term    = SHORT_TERM_RST;
        margin        = MARGIN_RST;

        rows = '{
            '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                16'sd0}, int'(CAUSE_POS)},
            '{'{-16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                16'sd0, 16'sd0}, int'(CAUSE_GOAL)},
            '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, int'(CAUSE_POS)},
            '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
                int'(CAUSE_POS)},
            '{'{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd0,
                16'sd0, 16'sd32767, 16'sd0, 16'sd0}, int'(CAUSE_NONE)},
            '{'{16'sd0, -16'sd5000, 16'sd0, 16'sd5000, -16'sd2000, 16'sd0, 16'sd0,
                16'sd2000, 16'sd0, 16'sd0}, int'(CAUSE_CROSS)},
            '{'{-16'sd5000, 16'sd0, 16'sd5000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd100,
                16'sd0, 16'sd0}, int'(CAUSE_OVERLAP)},
            '{'{-16'sd5000, 16'sd3000, 16'sd5000, 16'sd3000, -16'sd100, 16'sd0, 16'sd0,
                16'sd100, 16'sd0, 16'sd0}, int'(CAUSE_NONE)},
            '{'{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767,
                -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767}, -1},
            '{'{16'sd0, 16'sd9000, 16'sd0, 16'sd9000, 16'sd0, 16'sd0, -16'sd32768, 16'sd0,
                16'sd0, 16'sd32767}, -1},
            '{'{16'sd100, 16'sd0, 16'sd100, 16'sd0, -16'sd5000, 16'sd0, 16'sd0,
                16'sd5000, 16'sd0, 16'sd0}, -1},
            '{'{16'sd0, -16'sd4000, 16'sd0, 16'sd0, -16'sd3000, 16'sd0, 16'sd0, 16'sd3000,
                16'sd0, 16'sd0}, -1},
            '{'{16'sd3000, 16'sd3000, -16'sd3000, -16'sd3000, 16'sd0, 16'sd0, 16'sd0,
                16'sd0, 16'sd0, 16'sd0}, -1},
            '{'{16'sd1000, 16'sd1000, 16'sd4000, 16'sd4000, 16'sd4000, 16'sd4000, 16'sd0,
                16'sd7000, 16'sd7000, 16'sd0}, -1}
        };

        cfg_set = '{
            '{16'd0, 16'd0},         '{16'd65535, 16'd65535},
            '{16'd0, 16'd65535},     '{16'd65535, 16'd0},
            '{16'd1229, 16'd512},    '{16'd0, 16'd300},
            '{16'd100, 16'd20},      '{16'd3000, 16'd2000}
        };
        cfg_set[7][0] = CFG_W'($urandom_range(0, 65535));
        cfg_set[7][1] = CFG_W'($urandom_range(0, 65535));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send(rows[i].pkt, rows[i].want);
        for (int n = 0; n < 140; n++)
            send(make_item(), -1);

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            write_reg(REG_SHORT_TERM, cfg_set[ph][0]);
            write_reg(REG_MARGIN, cfg_set[ph][1]);
            quiet = (ph == 1 || ph == 3 || ph == 6);
            hold_req = (ph == 1);
            for (int n = 0; n < 125; n++)
            begin
                if (ph == 4 && n == 60)
                    drain();
                send(make_item(), -1);
            end
        end

        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
